// ===== rtl/core/qws_pkg.sv =====
`timescale 1ns / 1ps
// qws_pkg: widths, constants and the quarter-wave sine table builder
// used by quarter_wave_sincos_top; no dependencies
package qws_pkg;

  // table geometry
  localparam int QuarterTableSize = 256;
  localparam int TwoQuarterSize   = 2 * QuarterTableSize;
  localparam int SampleFracBits   = 15;

  // entry holds 0..1.0 with SampleFracBits fraction bits
  localparam int EntryW = SampleFracBits + 1;
  // table address covers 0..QuarterTableSize
  localparam int IdxW   = $clog2(QuarterTableSize + 1);
  // quarter position (Q0.30, up to 1.0) times table size
  localparam int PosW   = 30 + IdxW;
  // interpolated value, EntryW + 30 fraction bits, signed, with headroom
  localparam int ValW   = EntryW + 32;
  // shift from interpolated value down to Q1.15
  localparam int OutShift = SampleFracBits + 15;

  localparam logic [31:0] InvTwoPiQ32 = 32'd683565276;
  localparam logic [63:0] PiQ30       = 64'd3373259426;
  localparam logic [63:0] Q30One      = 64'd1 << 30;

  typedef logic [EntryW-1:0] rom_t [0:QuarterTableSize];

  // integer taylor series of sin(x), x and result in Q30
  function automatic logic [63:0] series_sine_q30(logic [63:0] x);
    logic        [63:0] x2;
    logic        [63:0] term;
    logic signed [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd272;
    sum  = sum + $signed(term);
    if (sum < 0) begin
      sum = '0;
    end
    if ($unsigned(sum) > Q30One) begin
      sum = $signed(Q30One);
    end
    return $unsigned(sum);
  endfunction

  // entry i = sin(i*pi/(2*size)), rounded half up to SampleFracBits
  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] x;
    logic [63:0] s;
    for (int i = 0; i <= QuarterTableSize; i++) begin
      x = (64'(i) * PiQ30 + 64'(QuarterTableSize)) / TwoQuarterSize;
      s = series_sine_q30(x);
      if (SampleFracBits < 30) begin
        s = (s + (64'd1 << (29 - SampleFracBits))) >> (30 - SampleFracBits);
      end
      r[i] = s[EntryW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/quarter_wave_sincos_top.sv =====
`timescale 1ns / 1ps
// quarter_wave_sincos_top: sine and cosine of a Q15.16 radian angle from a
// quarter-wave sine table with optional linear interpolation; uses qws_pkg
//
//  channel   signals                          dir  notes
//  angle     valid_i, stall_o, angle_i        in   one angle per item
//  result    valid_o, stall_i, sine_o/cosine_o out one result per angle
//  config    cfg_we_i, cfg_wdata_i            in   interp_enable, reset 1
//
// five register stages: angle, phase, table read, interpolation product,
// output; one item is taken every cycle while the output is not stalled, as
// the table read and each multiplier finish within their own stage
// reset clears the pipeline's valid flags only; the table is constant, so no
// clearing pass is needed. a stage loads whenever it is empty or the stage
// after it loads, so bubbles close up while the output is stalled
module quarter_wave_sincos_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [31:0] angle_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [15:0] sine_o,
  output logic [15:0] cosine_o,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i
);

  localparam qws_pkg::rom_t SineRom = qws_pkg::build_rom();
  localparam logic [qws_pkg::IdxW-1:0] LastIdx = qws_pkg::IdxW'(qws_pkg::QuarterTableSize);

  // configuration
  logic interp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interp_q <= 1'b1;
    end else if (cfg_we_i) begin
      interp_q <= cfg_wdata_i;
    end
  end

  // stage advance chain, from the output backward
  logic st1_vld_q, st2_vld_q, st3_vld_q, st4_vld_q, out_vld_q;
  logic adv1, adv2, adv3, adv4, adv_out;

  assign adv_out = !out_vld_q || !stall_i;
  assign adv4    = !st4_vld_q || adv_out;
  assign adv3    = !st3_vld_q || adv4;
  assign adv2    = !st2_vld_q || adv3;
  assign adv1    = !st1_vld_q || adv2;
  assign stall_o = !adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_vld_q <= 1'b0;
      st2_vld_q <= 1'b0;
      st3_vld_q <= 1'b0;
      st4_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv1)    st1_vld_q <= valid_i;
      if (adv2)    st2_vld_q <= st1_vld_q;
      if (adv3)    st3_vld_q <= st2_vld_q;
      if (adv4)    st4_vld_q <= st3_vld_q;
      if (adv_out) out_vld_q <= st4_vld_q;
    end
  end

  // stage 1: input register
  logic [31:0] angle_q;

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      angle_q <= angle_i;
    end
  end

  // stage 2: phase in turns = bits 47..16 of angle * 1/(2*pi) in Q0.32
  logic signed [63:0] turn_prod;
  logic        [31:0] phase_d, phase_q;

  assign turn_prod = 64'($signed(angle_q)) * $signed({32'd0, qws_pkg::InvTwoPiQ32});
  assign phase_d   = turn_prod[47:16];

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      phase_q <= phase_d;
    end
  end

  // stage 3: quadrant fold, table addresses and the registered table read
  logic [1:0]                quad;
  logic [29:0]               pofs;
  logic [30:0]               mpos;
  logic [qws_pkg::PosW-1:0]  tpos;
  logic [qws_pkg::IdxW-1:0]  idx_raw, idx;
  logic [29:0]               frac_d;
  logic [qws_pkg::IdxW-1:0]  addr_s0, addr_s1, addr_c0, addr_c1;

  assign quad = phase_q[31:30];
  assign pofs = phase_q[29:0];
  // quadrants 1 and 3 run backward through the quarter
  assign mpos = quad[0] ? (31'd1 << 30) - {1'b0, pofs} : {1'b0, pofs};
  assign tpos = qws_pkg::PosW'(mpos) * qws_pkg::PosW'(qws_pkg::QuarterTableSize);
  assign idx_raw = tpos[qws_pkg::PosW-1:30];

  always_comb begin
    idx    = idx_raw;
    frac_d = tpos[29:0];
    // exact quarter end: last entry, nothing to interpolate
    if (idx_raw >= LastIdx) begin
      idx    = LastIdx;
      frac_d = '0;
    end
    if (!interp_q) begin
      frac_d = '0;
    end
  end

  assign addr_s0 = idx;
  assign addr_s1 = (idx == LastIdx) ? LastIdx : idx + 1'b1;
  assign addr_c1 = LastIdx - idx;
  assign addr_c0 = (idx == LastIdx) ? '0 : LastIdx - idx - 1'b1;

  logic [qws_pkg::EntryW-1:0] rom_s0_q, rom_s1_q, rom_c0_q, rom_c1_q;
  logic [29:0]                frac_q;
  logic [1:0]                 quad3_q;

  // sine side table copy, two read ports
  always_ff @(posedge clk_i) begin
    if (adv3) begin
      rom_s0_q <= SineRom[addr_s0];
      rom_s1_q <= SineRom[addr_s1];
    end
  end

  // cosine side table copy, two read ports
  always_ff @(posedge clk_i) begin
    if (adv3) begin
      rom_c0_q <= SineRom[addr_c0];
      rom_c1_q <= SineRom[addr_c1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      frac_q  <= frac_d;
      quad3_q <= quad;
    end
  end

  // stage 4: interpolation products frac * slope
  logic signed [qws_pkg::ValW-1:0] frac_ext, dif_s, dif_c;
  logic signed [qws_pkg::ValW-1:0] prod_s_d, prod_c_d, prod_s_q, prod_c_q;
  logic [qws_pkg::EntryW-1:0]      base_s_q, base_c_q;
  logic [1:0]                      quad4_q;

  assign frac_ext = $signed(qws_pkg::ValW'(frac_q));
  assign dif_s    = $signed(qws_pkg::ValW'(rom_s1_q)) - $signed(qws_pkg::ValW'(rom_s0_q));
  assign dif_c    = $signed(qws_pkg::ValW'(rom_c1_q)) - $signed(qws_pkg::ValW'(rom_c0_q));
  assign prod_s_d = frac_ext * dif_s;
  assign prod_c_d = frac_ext * dif_c;

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      prod_s_q <= prod_s_d;
      prod_c_q <= prod_c_d;
      base_s_q <= rom_s0_q;
      base_c_q <= rom_c1_q;
      quad4_q  <= quad3_q;
    end
  end

  // stage 5: sum, round half up to Q1.15, clamp, quadrant sign
  logic signed [qws_pkg::ValW-1:0] sum_s, sum_c, rnd_s, rnd_c;
  logic [14:0]                     mag_s, mag_c;
  logic [15:0]                     sine_d, cosine_d, sine_q, cosine_q;
  logic                            neg_s, neg_c;

  localparam logic signed [qws_pkg::ValW-1:0] RndHalf =
    qws_pkg::ValW'(1) <<< (qws_pkg::OutShift - 1);
  localparam logic signed [qws_pkg::ValW-1:0] MagMax = qws_pkg::ValW'(32767);

  assign sum_s = ($signed(qws_pkg::ValW'(base_s_q)) <<< 30) + prod_s_q;
  assign sum_c = ($signed(qws_pkg::ValW'(base_c_q)) <<< 30) - prod_c_q;

  always_comb begin
    rnd_s = (sum_s < 0) ? '0 : (sum_s + RndHalf) >>> qws_pkg::OutShift;
    rnd_c = (sum_c < 0) ? '0 : (sum_c + RndHalf) >>> qws_pkg::OutShift;
    mag_s = (rnd_s > MagMax) ? 15'h7fff : rnd_s[14:0];
    mag_c = (rnd_c > MagMax) ? 15'h7fff : rnd_c[14:0];
  end

  assign neg_s    = quad4_q[1];
  assign neg_c    = quad4_q[1] ^ quad4_q[0];
  // a zero magnitude negates to zero
  assign sine_d   = neg_s ? 16'd0 - {1'b0, mag_s} : {1'b0, mag_s};
  assign cosine_d = neg_c ? 16'd0 - {1'b0, mag_c} : {1'b0, mag_c};

  always_ff @(posedge clk_i) begin
    if (adv_out) begin
      sine_q   <= sine_d;
      cosine_q <= cosine_d;
    end
  end

  assign valid_o  = out_vld_q;
  assign sine_o   = sine_q;
  assign cosine_o = cosine_q;

endmodule
